// ===== rtl/cop_pkg.sv =====
`default_nettype none

package cop_pkg;

    localparam int FB_WIDTH_DEF   = 320;
    localparam int FB_HEIGHT_DEF  = 200;
    localparam int CURSOR_MAX_DEF = 64;

    // wide enough for the sprite address at the largest cursor size
    localparam int SPR_ADDR_MAX_W = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] CMD_COMPOSE = 2'd0;
    localparam logic [1:0] CMD_PAL_WR  = 2'd1;
    localparam logic [1:0] CMD_SPR_WR  = 2'd2;

    localparam logic [2:0] REG_CURSOR_X = 3'd0;
    localparam logic [2:0] REG_CURSOR_Y = 3'd1;
    localparam logic [2:0] REG_HOT_X    = 3'd2;
    localparam logic [2:0] REG_HOT_Y    = 3'd3;
    localparam logic [2:0] REG_CUR_W    = 3'd4;
    localparam logic [2:0] REG_CUR_H    = 3'd5;
    localparam logic [2:0] REG_KEY      = 3'd6;
    localparam logic [2:0] REG_CONTROL  = 3'd7;

    localparam int CTRL_VISIBLE = 0;
    localparam int CTRL_OVERLAY = 1;

    typedef enum logic [1:0] {
        K_COMPOSE,
        K_PAL_WR,
        K_SPR_WR
    } t_kind;

    typedef struct packed {
        logic [8:0] cursor_x;
        logic [7:0] cursor_y;
        logic [5:0] hot_x;
        logic [5:0] hot_y;
        logic [6:0] cur_w;
        logic [6:0] cur_h;
        logic [7:0] key_color;
        logic [1:0] control;
    } t_cfg;

    typedef struct packed {
        t_kind                     kind;
        logic                      win;       // pixel lies inside the visible cursor box
        logic [SPR_ADDR_MAX_W-1:0] spr_addr;
        logic [7:0]                game_index;
        logic [15:0]               overlay_color;
        logic [7:0]                entry_index;
        logic [23:0]               entry_color;
        logic [7:0]                sprite_value;
    } t_item;

    // high-bit replication of 5- and 6-bit channels
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cursor_overlay_pixel_compositor.sv =====
`default_nettype none

// Cursor overlay compositor. Takes one item per clock on the slave stream unless
// a full queue holds it off and, for each compose item, gives one pixel on the
// master stream; palette and sprite loads give nothing. A front register classifies
// the item and works out the cursor-relative sprite coordinates, a four-item queue
// decouples it from the back pipeline, which reads the sprite store, then the
// palette, then loads the output register. Sustained rate is one item per clock
// while the master stream does not stall, set by the single port of each store.
// The palette reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed; sprite pixels must be loaded before use. The user must
// write registers through the config port only while the block is idle; the
// block itself does not enforce this.
module cursor_overlay_pixel_compositor #(
    parameter int FB_WIDTH   = cop_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT  = cop_pkg::FB_HEIGHT_DEF,
    parameter int CURSOR_MAX = cop_pkg::CURSOR_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // pos_x[8:0], pos_y[16:9], game_index[24:17], overlay_color[40:25],
    // entry_index[48:41], entry_color[72:49], sprite_value[80:73], zero pad
    input  wire logic [87:0] i_s_tdata,
    // command[1:0]
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // color_index[7:0], red[15:8], green[23:16], blue[31:24]
    output logic [31:0]      o_m_tdata
);
    import cop_pkg::*;

    t_cfg  r_cfg;
    t_item w_item_f;
    t_item w_item_q;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_nonempty;
    logic [8:0] w_cx_clamp;
    logic [7:0] w_cy_clamp;
    logic [6:0] w_w_clamp;
    logic [6:0] w_h_clamp;

    assign w_cx_clamp = ({4'b0, i_cfg_data} > 13'(FB_WIDTH - 1))
                      ? 9'(FB_WIDTH - 1) : i_cfg_data;
    assign w_cy_clamp = ({5'b0, i_cfg_data[7:0]} > 13'(FB_HEIGHT - 1))
                      ? 8'(FB_HEIGHT - 1) : i_cfg_data[7:0];
    assign w_w_clamp  = ({2'b0, i_cfg_data[6:0]} > 9'(CURSOR_MAX))
                      ? 7'(CURSOR_MAX) : i_cfg_data[6:0];
    assign w_h_clamp  = w_w_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CURSOR_X: r_cfg.cursor_x  <= w_cx_clamp;
                REG_CURSOR_Y: r_cfg.cursor_y  <= w_cy_clamp;
                REG_HOT_X:    r_cfg.hot_x     <= i_cfg_data[5:0];
                REG_HOT_Y:    r_cfg.hot_y     <= i_cfg_data[5:0];
                REG_CUR_W:    r_cfg.cur_w     <= w_w_clamp;
                REG_CUR_H:    r_cfg.cur_h     <= w_h_clamp;
                REG_KEY:      r_cfg.key_color <= i_cfg_data[7:0];
                REG_CONTROL:  r_cfg.control   <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    cop_front #(
        .FB_WIDTH   (FB_WIDTH),
        .FB_HEIGHT  (FB_HEIGHT),
        .CURSOR_MAX (CURSOR_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_s_tvalid),
        .o_ready         (o_s_tready),
        .i_command       (i_s_tuser),
        .i_pos_x         (i_s_tdata[8:0]),
        .i_pos_y         (i_s_tdata[16:9]),
        .i_game_index    (i_s_tdata[24:17]),
        .i_overlay_color (i_s_tdata[40:25]),
        .i_entry_index   (i_s_tdata[48:41]),
        .i_entry_color   (i_s_tdata[72:49]),
        .i_sprite_value  (i_s_tdata[80:73]),
        .o_push          (w_push),
        .o_item          (w_item_f),
        .i_full          (w_full)
    );

    cop_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_item_f),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_item     (w_item_q)
    );

    cop_back #(
        .CURSOR_MAX (CURSOR_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_nonempty    (w_nonempty),
        .i_item        (w_item_q),
        .o_pop         (w_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_color_index (o_m_tdata[7:0]),
        .o_red         (o_m_tdata[15:8]),
        .o_green       (o_m_tdata[23:16]),
        .o_blue        (o_m_tdata[31:24])
    );

endmodule

`default_nettype wire

// ===== rtl/cop_front.sv =====
`default_nettype none

module cop_front #(
    parameter int FB_WIDTH   = cop_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT  = cop_pkg::FB_HEIGHT_DEF,
    parameter int CURSOR_MAX = cop_pkg::CURSOR_MAX_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cop_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_command,
    input  wire logic [8:0]    i_pos_x,
    input  wire logic [7:0]    i_pos_y,
    input  wire logic [7:0]    i_game_index,
    input  wire logic [15:0]   i_overlay_color,
    input  wire logic [7:0]    i_entry_index,
    input  wire logic [23:0]   i_entry_color,
    input  wire logic [7:0]    i_sprite_value,
    output logic               o_push,
    output cop_pkg::t_item     o_item,
    input  wire logic          i_full
);
    import cop_pkg::*;

    logic        r_fv;
    t_item       r_item;
    t_item       n_item;
    logic        w_keep;
    logic        w_accept;
    logic signed [12:0] w_cx;
    logic signed [12:0] w_cy;
    logic        w_in_fb;
    logic        w_in_box;
    logic        w_spr_ok;

    assign o_ready  = !r_fv || !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = r_fv && !i_full;
    assign o_item   = r_item;

    // sprite coordinates of the pixel, hotspot placed at the cursor position
    assign w_cx = $signed({4'b0, i_pos_x}) - $signed({4'b0, i_cfg.cursor_x})
                + $signed({7'b0, i_cfg.hot_x});
    assign w_cy = $signed({5'b0, i_pos_y}) - $signed({5'b0, i_cfg.cursor_y})
                + $signed({7'b0, i_cfg.hot_y});

    assign w_in_fb = ({4'b0, i_pos_x} < 13'(FB_WIDTH)) && ({5'b0, i_pos_y} < 13'(FB_HEIGHT));

    assign w_in_box = i_cfg.control[CTRL_VISIBLE] && (i_cfg.cur_w != '0)
                   && (i_cfg.cur_h != '0) && !w_cx[12] && !w_cy[12]
                   && ($unsigned(w_cx) < {6'b0, i_cfg.cur_w})
                   && ($unsigned(w_cy) < {6'b0, i_cfg.cur_h});

    assign w_spr_ok = ({4'b0, i_pos_x} < 13'(CURSOR_MAX)) && ({5'b0, i_pos_y} < 13'(CURSOR_MAX));

    always_comb begin
        n_item               = '0;
        n_item.game_index    = i_game_index;
        n_item.overlay_color = i_overlay_color;
        n_item.entry_index   = i_entry_index;
        n_item.entry_color   = i_entry_color;
        n_item.sprite_value  = i_sprite_value;
        w_keep               = 1'b0;
        case (i_command)
            CMD_COMPOSE: begin
                w_keep          = 1'b1;
                n_item.kind     = K_COMPOSE;
                n_item.win      = w_in_fb && w_in_box;
                n_item.spr_addr = SPR_ADDR_MAX_W'(w_cy[7:0]) * SPR_ADDR_MAX_W'(CURSOR_MAX)
                                + SPR_ADDR_MAX_W'(w_cx[7:0]);
            end
            CMD_PAL_WR: begin
                w_keep      = 1'b1;
                n_item.kind = K_PAL_WR;
            end
            CMD_SPR_WR: begin
                w_keep          = w_spr_ok;
                n_item.kind     = K_SPR_WR;
                n_item.spr_addr = SPR_ADDR_MAX_W'(i_pos_y) * SPR_ADDR_MAX_W'(CURSOR_MAX)
                                + SPR_ADDR_MAX_W'(i_pos_x);
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_accept) begin
            r_fv <= w_keep;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cop_fifo.sv =====
`default_nettype none

module cop_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cop_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_nonempty,
    output cop_pkg::t_item      o_item
);
    import cop_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_full     = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + (PW+1)'(1)))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== rtl/cop_back.sv =====
`default_nettype none

module cop_back #(
    parameter int CURSOR_MAX = cop_pkg::CURSOR_MAX_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cop_pkg::t_cfg  i_cfg,
    input  wire logic           i_nonempty,
    input  wire cop_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_color_index,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue
);
    import cop_pkg::*;

    localparam int SPR_DEPTH = CURSOR_MAX * CURSOR_MAX;
    localparam int AW        = $clog2(SPR_DEPTH);

    logic [7:0]  r_spr_mem [SPR_DEPTH];
    logic [23:0] r_pal_mem [256];
    logic [255:0] r_pal_valid;

    logic        w_en;

    // stage 1: sprite store access
    logic        r_v1;
    t_item       r_it1;
    logic [7:0]  r_spr;

    // stage 2: key compare and palette access
    logic        r_v2;
    t_item       r_it2;
    logic        r_hit2;
    logic [7:0]  r_cv2;
    logic [23:0] r_pal;
    logic        r_pal_ok;

    // stage 3: output register
    logic        r_v3;
    logic [7:0]  r_idx;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    logic [7:0]  n_idx;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;
    logic [23:0] w_pal_color;

    assign w_en  = !r_v3 || i_ready;
    assign o_pop = w_en && i_nonempty;

    assign o_valid       = r_v3;
    assign o_color_index = r_idx;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_nonempty;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && (r_it2.kind == K_COMPOSE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (i_nonempty && (i_item.kind == K_SPR_WR)) begin
                r_spr_mem[i_item.spr_addr[AW-1:0]] <= i_item.sprite_value;
            end
            r_spr <= r_spr_mem[i_item.spr_addr[AW-1:0]];
            r_it1 <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_v1 && (r_it1.kind == K_PAL_WR)) begin
                r_pal_mem[r_it1.entry_index] <= r_it1.entry_color;
            end
            r_pal  <= r_pal_mem[r_spr];
            r_it2  <= r_it1;
            r_cv2  <= r_spr;
            r_hit2 <= r_it1.win && (r_spr != i_cfg.key_color);
        end
    end

    // per-entry valid bits stand in for clearing the palette at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_valid <= '0;
        end else if (w_en && r_v1 && (r_it1.kind == K_PAL_WR)) begin
            r_pal_valid[r_it1.entry_index] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pal_ok <= r_pal_valid[r_spr];
        end
    end

    assign w_pal_color = r_pal_ok ? r_pal : 24'd0;

    always_comb begin
        n_idx   = 8'd0;
        n_red   = 8'd0;
        n_green = 8'd0;
        n_blue  = 8'd0;
        if (!i_cfg.control[CTRL_OVERLAY]) begin
            n_idx = r_hit2 ? r_cv2 : r_it2.game_index;
        end else if (r_hit2) begin
            n_red   = w_pal_color[23:16];
            n_green = w_pal_color[15:8];
            n_blue  = w_pal_color[7:0];
        end else begin
            n_red   = widen5(r_it2.overlay_color[15:11]);
            n_green = widen6(r_it2.overlay_color[10:5]);
            n_blue  = widen5(r_it2.overlay_color[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx   <= n_idx;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_v1) |=> r_v1)
        else $error("stage 1 item dropped during stall");

    a_only_compose_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_v2 && (r_it2.kind != K_COMPOSE)) |=> !r_v3)
        else $error("load item produced a result");

    a_pop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_v1)
        else $error("popped item not in stage 1");

endmodule

`default_nettype wire
